/* design/dpp_pkg.sv */
// shared constants for the dynamic priority process pick
`default_nettype none

package dpp_pkg;

    localparam int SLOT_COUNT_DEFAULT = 64;

    // field widths
    localparam int PRIO_W  = 7;
    localparam int TICK_W  = 16;
    localparam int STAMP_W = 32;
    localparam int OUT_SLOT_W = 6;

    // niceness arithmetic
    localparam int NICE_W    = 4;
    localparam int NUM_W     = TICK_W + 4;
    localparam int DEN_W     = TICK_W + 1;
    localparam int DIV_STEPS = NICE_W;

    localparam logic [NICE_W-1:0] NICE_DEFAULT = NICE_W'(5);
    localparam logic [PRIO_W-1:0] PRIO_OFFSET  = PRIO_W'(5);
    localparam logic [PRIO_W-1:0] PRIO_MAX     = PRIO_W'(100);

endpackage

`default_nettype wire

/* design/dynamic_priority_process_pick.sv */
// Dynamic priority process pick: one process-slot record per item, in slot
// order, with the last record of a round marked. Each record is accepted when
// start is high and busy is low. busy then stays high through the S_DIV
// state, in which a shared compare-and-subtract unit divides sleep*10 by
// run+sleep one quotient bit at a time, and the S_PICK state, which forms the
// clamped dynamic priority and updates the best slot (lowest priority, then
// fewest runs, then earliest creation, then lowest index). A record is taken
// only while the block is idle, so the next record cannot come in before the
// last one is through. On the marked record the result is shown for one cycle
// with done high, in the first cycle with busy low; the receiver cannot stall
// it. found is low and the other fields are zero when no runnable slot was
// seen. Slot indexes wrap at SLOT_COUNT and are reported in six bits.
`default_nettype none

module dynamic_priority_process_pick
    import dpp_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  runnable,
    input  wire logic [PRIO_W-1:0]     static_priority,
    input  wire logic [TICK_W-1:0]     recent_run,
    input  wire logic [TICK_W-1:0]     recent_sleep,
    input  wire logic [TICK_W-1:0]     run_count,
    input  wire logic [STAMP_W-1:0]    created_at,
    input  wire logic                  scheduled_before,
    input  wire logic                  last_slot,
    output logic                       done,
    output logic                       found,
    output logic [OUT_SLOT_W-1:0]      chosen_slot,
    output logic [PRIO_W-1:0]          chosen_priority
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PICK
    } state_t;

    state_t                 state_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [NUM_W-1:0]       rem_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [NICE_W-1:0]      quot_reg;

    // latched beat
    logic                   runnable_reg;
    logic                   last_reg;
    logic                   eligible_reg;
    logic [PRIO_W-1:0]      stat_reg;
    logic [TICK_W-1:0]      runs_reg;
    logic [STAMP_W-1:0]     created_reg;

    // round state
    logic [SLOT_W-1:0]      slot_reg;
    logic                   best_valid_reg;
    logic [SLOT_W-1:0]      best_slot_reg;
    logic [PRIO_W-1:0]      best_prio_reg;
    logic [TICK_W-1:0]      best_runs_reg;
    logic [STAMP_W-1:0]     best_created_reg;

    // registered result
    logic                   done_reg;
    logic                   found_reg;
    logic [OUT_SLOT_W-1:0]  chosen_slot_reg;
    logic [PRIO_W-1:0]      chosen_prio_reg;

    logic                   accept;
    logic [NUM_W-1:0]       num_in;
    logic [DEN_W-1:0]       den_in;
    logic [NUM_W-1:0]       trial;
    logic                   fits;
    logic [NICE_W-1:0]      nice;
    logic [PRIO_W+1:0]      prio_raw;
    logic [PRIO_W-1:0]      prio;
    logic                   take;
    logic [SLOT_W-1:0]      win_slot;
    logic [PRIO_W-1:0]      win_prio;
    logic [SLOT_W+OUT_SLOT_W-1:0] win_slot_ext;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign num_in = (NUM_W'(recent_sleep) << 3) + (NUM_W'(recent_sleep) << 1);
    assign den_in = DEN_W'(recent_run) + DEN_W'(recent_sleep);

    // shared compare-and-subtract, one quotient bit per cycle
    assign trial = NUM_W'(den_reg) << step_reg;
    assign fits  = (rem_reg >= trial);

    assign nice = eligible_reg ? quot_reg : NICE_DEFAULT;

    always_comb
    begin
        prio_raw = (PRIO_W+2)'(stat_reg) + (PRIO_W+2)'(PRIO_OFFSET) - (PRIO_W+2)'(nice);
        priority if (prio_raw[PRIO_W+1])
            prio = '0;
        else if (prio_raw > (PRIO_W+2)'(PRIO_MAX))
            prio = PRIO_MAX;
        else
            prio = prio_raw[PRIO_W-1:0];
    end

    always_comb
    begin
        take = 1'b0;
        if (runnable_reg)
        begin
            priority if (!best_valid_reg)
                take = 1'b1;
            else if (prio != best_prio_reg)
                take = (prio < best_prio_reg);
            else if (runs_reg != best_runs_reg)
                take = (runs_reg < best_runs_reg);
            else
                take = (created_reg < best_created_reg);
        end
    end

    assign win_slot     = take ? slot_reg : best_slot_reg;
    assign win_prio     = take ? prio : best_prio_reg;
    assign win_slot_ext = (SLOT_W+OUT_SLOT_W)'(win_slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            slot_reg         <= '0;
            best_valid_reg   <= 1'b0;
            best_slot_reg    <= '0;
            best_prio_reg    <= '0;
            best_runs_reg    <= '0;
            best_created_reg <= '0;
            done_reg         <= 1'b0;
            found_reg        <= 1'b0;
            chosen_slot_reg  <= '0;
            chosen_prio_reg  <= '0;
        end
        else
        begin
            done_reg <= (state_reg == S_PICK) && last_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_DIV;
                        step_reg  <= STEP_TOP;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == '0)
                        state_reg <= S_PICK;
                    else
                        step_reg <= step_reg - 1'b1;
                end
                S_PICK:
                begin
                    state_reg <= S_IDLE;
                    if (last_reg)
                    begin
                        found_reg        <= best_valid_reg || take;
                        chosen_slot_reg  <= win_slot_ext[OUT_SLOT_W-1:0];
                        chosen_prio_reg  <= win_prio;
                        slot_reg         <= '0;
                        best_valid_reg   <= 1'b0;
                        best_slot_reg    <= '0;
                        best_prio_reg    <= '0;
                        best_runs_reg    <= '0;
                        best_created_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                        if (take)
                        begin
                            best_valid_reg   <= 1'b1;
                            best_slot_reg    <= slot_reg;
                            best_prio_reg    <= prio;
                            best_runs_reg    <= runs_reg;
                            best_created_reg <= created_reg;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            runnable_reg <= runnable;
            last_reg     <= last_slot;
            eligible_reg <= scheduled_before && (run_count != '0) && (den_in != '0);
            stat_reg     <= static_priority;
            runs_reg     <= run_count;
            created_reg  <= created_at;
            rem_reg      <= num_in;
            den_reg      <= den_in;
            quot_reg     <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            if (fits)
            begin
                rem_reg            <= rem_reg - trial;
                quot_reg[step_reg] <= 1'b1;
            end
        end
    end

    assign done            = done_reg;
    assign found           = found_reg;
    assign chosen_slot     = chosen_slot_reg;
    assign chosen_priority = chosen_prio_reg;

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_PICK))
        else $error("result without a pick cycle");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && (state_reg == S_DIV) && (step_reg == STEP_TOP))
        else $error("accepted beat did not start the divider");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (chosen_slot == '0) && (chosen_priority == '0))
        else $error("empty round reports nonzero fields");

    a_prio_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |-> (prio <= PRIO_MAX) && (quot_reg <= NICE_W'(10) || !eligible_reg))
        else $error("dynamic priority or niceness out of range");

endmodule

`default_nettype wire
